>>> hw/rtl/catf_pkg.sv
// ----------------------------------------------------------------------------
// catf_pkg
// Shared types and constants for the CSV age threshold filter.
// ----------------------------------------------------------------------------
package catf_pkg;

   // Input transaction: one byte of the text stream
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } catf_req_type;

   // Output transaction: a forwarded byte or an error report
   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [1:0]  error_code;
      logic [31:0] line_number;
      logic        last;
   } catf_rsp_type;

   // Result kinds
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_AGE_MISSING  = 2'd0;
   localparam logic [1:0] ERR_LINE_MISSING = 2'd1;
   localparam logic [1:0] ERR_NOT_NUMBER   = 2'd2;

   // Characters
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Age magnitude saturates here; it never passes a 16-bit threshold
   localparam logic [16:0] MAG_LIMIT = 17'd65536;

   // Tokenizer phase, one-hot
   typedef enum logic [6:0] {
      PH_FIRST_WAIT  = 7'b0000001,
      PH_FIRST_TOKEN = 7'b0000010,
      PH_SECOND_WAIT = 7'b0000100,
      PH_SPACE       = 7'b0001000,
      PH_SIGN        = 7'b0010000,
      PH_DIGITS      = 7'b0100000,
      PH_DONE        = 7'b1000000
   } parse_phase_type;

   // Control sequencer, one-hot
   typedef enum logic [2:0] {
      ST_ACCEPT = 3'b001,
      ST_READ   = 3'b010,
      ST_WAIT   = 3'b100
   } ctl_state_type;

endpackage

>>> hw/rtl/csv_age_threshold_filter.sv
// ----------------------------------------------------------------------------
// csv_age_threshold_filter
// Splits a CSV byte stream into lines, parses the second field as an age and
// forwards lines whose age is within the programmed threshold.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one stream byte per transaction, end_of_stream flags the final
//            byte and closes the current line.
//   rsp_*  : forwarded line bytes (kind 0) or a single error report (kind 1),
//            each tagged with the line number; last marks the final result
//            of the closing byte.
//   csr_*  : write max_age while the block is idle.
// Throughput: one byte per cycle while a line is collected. A line closes at
// a newline, at LINE_BYTES-1 bytes or at end_of_stream. A passing line of n
// bytes is then replayed from the line store, each byte by a store read
// (ST_READ) and an output load (ST_WAIT), during which req_ready is low; the
// first byte reaches rsp via ST_READ, ST_WAIT and the output register. An error
// report shows in the cycle after the closing byte. Dropped lines give no output.
// A result waiting on rsp_ready stalls replay; input is taken only when the
// output register is free or is being drained in the same cycle.
// Reset clears the tokenizer, the line count and max_age; the line store
// needs no clearing since only bytes of the current line are read back.
// ----------------------------------------------------------------------------
module csv_age_threshold_filter
   import catf_pkg::*;
#(
   parameter int LINE_BYTES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  catf_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output catf_rsp_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data
);

   localparam int ADDR_W = $clog2(LINE_BYTES);
   localparam logic [ADDR_W-1:0] LAST_COUNT = ADDR_W'(LINE_BYTES - 1);
   localparam logic [ADDR_W-1:0] ONE_COUNT  = ADDR_W'(1);

   // Registers
   ctl_state_type   state_ff, state_in;
   parse_phase_type phase_ff, phase_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [16:0]     mag_ff, mag_in;
   logic            minus_ff, minus_in;
   logic            digit_ff, digit_in;
   logic [31:0]     counter_ff, counter_in;
   logic [15:0]     max_age_ff, max_age_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   catf_rsp_type    rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic            req_fire;
   logic [7:0]      c;
   logic            is_comma, is_space, is_sign, is_digit, is_newline;
   logic            value_step, space_like;
   logic [20:0]     mag_prod;
   logic [16:0]     mag_sat;
   logic            chunk_end, early_phase, age_pass;
   logic            out_free;
   logic [7:0]      ram_rd_data;

   assign req_fire = req_valid && req_ready;
   assign c        = req_data.in_byte;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Input is taken only while collecting and with room for an error report
   assign req_ready = (state_ff == ST_ACCEPT) && out_free;

   // Line store; writes happen only while collecting and reads only while
   // replaying, so one entry is never written and read in the same cycle
   catf_ram #(
      .WIDTH (8),
      .DEPTH (LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (count_ff),
      .wr_data (c),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Character classes
   assign is_comma   = (c == CHAR_COMMA);
   assign is_newline = (c == CHAR_NEWLINE);
   assign is_space   = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   assign is_sign    = (c == CHAR_PLUS) || (c == CHAR_MINUS);
   assign is_digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

   // Decimal accumulate: mag * 10 + digit, saturating
   assign mag_prod = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {17'b0, c[3:0]};
   assign mag_sat  = (mag_prod > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : mag_prod[16:0];

   // Tokenizer
   always_comb begin
      phase_in   = phase_ff;
      mag_in     = mag_ff;
      minus_in   = minus_ff;
      digit_in   = digit_ff;
      value_step = 1'b0;
      space_like = (phase_ff == PH_SPACE) || (phase_ff == PH_SECOND_WAIT);
      unique case (phase_ff) inside
         PH_FIRST_WAIT: begin
            if (!is_comma) phase_in = PH_FIRST_TOKEN;
         end
         PH_FIRST_TOKEN: begin
            if (is_comma) phase_in = PH_SECOND_WAIT;
         end
         PH_SECOND_WAIT: begin
            if (!is_comma) value_step = 1'b1;
         end
         PH_SPACE, PH_SIGN, PH_DIGITS: begin
            if (is_comma) phase_in = PH_DONE;
            else value_step = 1'b1;
         end
         default: begin
         end
      endcase
      // Value parsing within the second token
      if (value_step) begin
         if (space_like && is_space) begin
            phase_in = PH_SPACE;
         end else if (space_like && is_sign) begin
            phase_in = PH_SIGN;
            minus_in = (c == CHAR_MINUS);
         end else if (is_digit) begin
            phase_in = PH_DIGITS;
            mag_in   = mag_sat;
            digit_in = 1'b1;
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   // Line close and verdict, on the state after this byte
   always_comb begin
      count_in    = count_ff + ONE_COUNT;
      chunk_end   = is_newline || (count_in >= LAST_COUNT) || req_data.end_of_stream;
      early_phase = (phase_in == PH_FIRST_WAIT) || (phase_in == PH_FIRST_TOKEN) ||
                    (phase_in == PH_SECOND_WAIT);
      age_pass    = (!minus_in || (mag_in == 17'd0)) && (mag_in <= {1'b0, max_age_ff});
   end

   // Sequencer and output register
   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      max_age_in   = csr_write_enable ? csr_write_data : max_age_ff;

      unique case (state_ff)
         ST_ACCEPT: begin
            if (req_fire && chunk_end) begin
               counter_in              = counter_ff + 32'd1;
               rsp_data_in.kind        = KIND_ERROR;
               rsp_data_in.out_byte    = 8'h00;
               rsp_data_in.line_number = counter_in;
               rsp_data_in.last        = 1'b1;
               if ((count_in == ONE_COUNT) && is_newline) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.error_code = ERR_LINE_MISSING;
               end else if ((count_in == ONE_COUNT) || early_phase) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.error_code = ERR_AGE_MISSING;
               end else if (!digit_in) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.error_code = ERR_NOT_NUMBER;
               end else if (age_pass) begin
                  state_in  = ST_READ;
                  len_in    = count_in;
                  rd_idx_in = '0;
               end
            end
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            // Store data is held until the output register has room
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = KIND_BYTE;
               rsp_data_in.out_byte    = ram_rd_data;
               rsp_data_in.error_code  = ERR_AGE_MISSING;
               rsp_data_in.line_number = counter_ff;
               rsp_data_in.last        = (rd_idx_ff == (len_ff - ONE_COUNT));
               rd_idx_in               = rd_idx_ff + ONE_COUNT;
               state_in = rsp_data_in.last ? ST_ACCEPT : ST_READ;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         phase_ff     <= PH_FIRST_WAIT;
         count_ff     <= '0;
         mag_ff       <= '0;
         minus_ff     <= 1'b0;
         digit_ff     <= 1'b0;
         counter_ff   <= '0;
         max_age_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         max_age_ff   <= max_age_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            if (chunk_end) begin
               phase_ff <= PH_FIRST_WAIT;
               count_ff <= '0;
               mag_ff   <= '0;
               minus_ff <= 1'b0;
               digit_ff <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               count_ff <= count_in;
               mag_ff   <= mag_in;
               minus_ff <= minus_in;
               digit_ff <= digit_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.kind == KIND_ERROR)) |-> rsp_data_ff.last)
      else $error("error report without last");

   a_replay_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACCEPT) |-> (len_ff >= 2))
      else $error("replay of a line shorter than two bytes");

   a_replay_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACCEPT) |-> (rd_idx_ff < len_ff))
      else $error("replay index past line length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < LAST_COUNT)
      else $error("byte count reached line limit without closing");

   a_last_byte_ends_replay: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WAIT) && out_free && (rd_idx_ff == (len_ff - ONE_COUNT)))
      |=> (state_ff == ST_ACCEPT) && rsp_valid_ff && rsp_data_ff.last)
      else $error("replay did not end on its last byte");

endmodule

>>> hw/rtl/catf_ram.sv
// ----------------------------------------------------------------------------
// catf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module catf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
